/* hdl/pesh_pkg.sv */
`timescale 1ns / 1ps

package pesh_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  MIN_ID_RESET  = 8'd188;
   localparam logic [23:0] PREFIX_CODE   = 24'h000001;
   localparam logic [23:0] WINDOW_EMPTY  = 24'hFFFFFF;
   localparam logic [1:0]  FILL_FULL     = 2'd3;
   localparam logic [15:0] SKIP_MAX      = 16'hFFFF;
   localparam logic [1:0]  FLAGS_INVALID = 2'd1;
   localparam logic [1:0]  FLAGS_PTS     = 2'd2;
   localparam logic [1:0]  FLAGS_PTS_DTS = 2'd3;
   localparam logic [3:0]  TS_BYTES_NONE = 4'd0;
   localparam logic [3:0]  TS_BYTES_PTS  = 4'd5;
   localparam logic [3:0]  TS_BYTES_BOTH = 4'd10;
   localparam logic [8:0]  HDR_FIXED     = 9'd3;
   localparam logic        STATUS_OK     = 1'b0;
   localparam logic        STATUS_FORMAT = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_FLAGS1,
      PH_FLAGS2,
      PH_HDRLEN,
      PH_HDRDATA
   } phase_type;

   typedef enum logic [2:0] {
      K_ID,
      K_LEN_HI,
      K_LEN_LO,
      K_FLAGS,
      K_HDRLEN,
      K_HDRDATA
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        ts_valid;
      logic [3:0]  ts_index;
      logic        emit;
      logic        status;
      logic [15:0] skipped;
   } word_type;

   typedef struct packed {
      logic [7:0]  stream_id;
      logic [15:0] packet_length;
      logic [1:0]  pts_dts_flags;
      logic [7:0]  hdr_length;
      logic [32:0] pts;
      logic [32:0] dts;
      logic [15:0] payload_len;
      logic        payload_unbounded;
      logic [15:0] skipped_bytes;
      logic        status;
   } result_type;

endpackage

/* hdl/pesh_front.sv */
`timescale 1ns / 1ps

module pesh_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   output logic              in_ready,
   input  logic              q_ready,
   output logic              q_push,
   output pesh_pkg::word_type q_word
);
   import pesh_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  min_id_ff;
   logic [23:0] window_ff, window_in;
   logic [1:0]  fill_ff, fill_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  left_ff, left_in;
   logic [3:0]  ts_idx_ff, ts_idx_in;
   logic [1:0]  flags_ff, flags_in;

   logic       accept;
   logic       match;
   logic       hdr_emit;
   logic       hdr_invalid;
   logic       data_last;
   logic       ts_take;
   logic [3:0] ts_need;

   assign in_ready    = q_ready;
   assign accept      = in_valid & q_ready;
   assign match       = (window_ff == PREFIX_CODE) && (in_byte >= min_id_ff);
   assign hdr_invalid = (flags_ff == FLAGS_INVALID);
   assign hdr_emit    = hdr_invalid || (in_byte == 8'd0);
   assign data_last   = (left_ff == 8'd1);
   assign ts_need     = (flags_ff == FLAGS_PTS_DTS) ? TS_BYTES_BOTH :
                        (flags_ff == FLAGS_PTS) ? TS_BYTES_PTS : TS_BYTES_NONE;
   assign ts_take     = (ts_idx_ff < ts_need);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT:    phase_in = match ? PH_LEN_HI : PH_HUNT;
            PH_LEN_HI:  phase_in = PH_LEN_LO;
            PH_LEN_LO:  phase_in = PH_FLAGS1;
            PH_FLAGS1:  phase_in = PH_FLAGS2;
            PH_FLAGS2:  phase_in = PH_HDRLEN;
            PH_HDRLEN:  phase_in = hdr_emit ? PH_HUNT : PH_HDRDATA;
            PH_HDRDATA: phase_in = data_last ? PH_HUNT : PH_HDRDATA;
            default:    phase_in = PH_HUNT;
         endcase
      end
   end

   // words to the back end
   always_comb begin
      q_push         = 1'b0;
      q_word         = '0;
      q_word.kind    = K_ID;
      q_word.data    = in_byte;
      q_word.skipped = skip_ff;
      q_word.ts_index = ts_idx_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            q_push      = accept & match;
            q_word.kind = K_ID;
         end
         PH_LEN_HI: begin
            q_push      = accept;
            q_word.kind = K_LEN_HI;
         end
         PH_LEN_LO: begin
            q_push      = accept;
            q_word.kind = K_LEN_LO;
         end
         PH_FLAGS1: begin
            q_push = 1'b0;
         end
         PH_FLAGS2: begin
            q_push      = accept;
            q_word.kind = K_FLAGS;
         end
         PH_HDRLEN: begin
            q_push        = accept;
            q_word.kind   = K_HDRLEN;
            q_word.emit   = hdr_emit;
            q_word.status = hdr_invalid ? STATUS_FORMAT : STATUS_OK;
         end
         PH_HDRDATA: begin
            q_push          = accept & (ts_take | data_last);
            q_word.kind     = K_HDRDATA;
            q_word.ts_valid = ts_take;
            q_word.emit     = data_last;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   // parser fields
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      skip_in   = skip_ff;
      left_in   = left_ff;
      ts_idx_in = ts_idx_ff;
      flags_in  = flags_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (!match) begin
                  window_in = {window_ff[15:0], in_byte};
                  if (fill_ff == FILL_FULL) begin
                     if (skip_ff != SKIP_MAX) skip_in = skip_ff + 16'd1;
                  end else begin
                     fill_in = fill_ff + 2'd1;
                  end
               end
            end
            PH_FLAGS2: begin
               flags_in = in_byte[7:6];
            end
            PH_HDRLEN: begin
               left_in   = in_byte;
               ts_idx_in = 4'd0;
               if (hdr_emit) begin
                  window_in = WINDOW_EMPTY;
                  fill_in   = 2'd0;
                  skip_in   = 16'd0;
               end
            end
            PH_HDRDATA: begin
               if (ts_take) ts_idx_in = ts_idx_ff + 4'd1;
               left_in = left_ff - 8'd1;
               if (data_last) begin
                  window_in = WINDOW_EMPTY;
                  fill_in   = 2'd0;
                  skip_in   = 16'd0;
               end
            end
            default: begin
               window_in = window_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         min_id_ff <= MIN_ID_RESET;
         window_ff <= WINDOW_EMPTY;
         fill_ff   <= 2'd0;
         skip_ff   <= 16'd0;
         left_ff   <= 8'd0;
         ts_idx_ff <= 4'd0;
         flags_ff  <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         fill_ff   <= fill_in;
         skip_ff   <= skip_in;
         left_ff   <= left_in;
         ts_idx_ff <= ts_idx_in;
         flags_ff  <= flags_in;
         if (csr_wr_en) min_id_ff <= csr_wr_data;
      end
   end

endmodule

/* hdl/pesh_queue.sv */
`timescale 1ns / 1ps

module pesh_queue #(
   parameter int DEPTH = pesh_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pesh_pkg::word_type push_word,
   output logic               ready,
   input  logic               pop,
   output pesh_pkg::word_type pop_word,
   output logic               valid
);
   import pesh_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   word_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign ready    = (count_ff != CNT_FULL);
   assign valid    = (count_ff != '0);
   assign pop_word = entry_ff[rd_ptr_ff];
   assign do_push  = push & ready;
   assign do_pop   = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_word;
   end

endmodule

/* hdl/pesh_back.sv */
`timescale 1ns / 1ps

module pesh_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  pesh_pkg::word_type   q_word,
   output logic                 q_pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pesh_pkg::result_type out_result
);
   import pesh_pkg::*;

   function automatic logic [32:0] ts_merge(input logic [32:0] acc, input logic [2:0] k,
                                            input logic [7:0] b);
      logic [32:0] r;
      r = acc;
      unique case (k)
         3'd0:    r = {b[3:1], 30'd0};
         3'd1:    r = acc | {3'd0, b, 22'd0};
         3'd2:    r = acc | {11'd0, b[7:1], 15'd0};
         3'd3:    r = acc | {18'd0, b, 7'd0};
         default: r = acc | {26'd0, b[7:1]};
      endcase
      return r;
   endfunction

   logic [7:0]  id_ff, id_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] len_ff, len_in;
   logic [1:0]  flags_ff, flags_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [32:0] pts_ff, pts_in;
   logic [32:0] dts_ff, dts_in;
   result_type  out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   logic        emit;
   logic [3:0]  dts_k;
   logic [8:0]  sub;
   logic [16:0] diff;

   assign q_pop      = q_valid & (!q_word.emit | !out_valid_ff | out_ready);
   assign emit       = q_pop & q_word.emit;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;
   assign dts_k      = q_word.ts_index - TS_BYTES_PTS;

   always_comb begin
      id_in    = id_ff;
      skip_in  = skip_ff;
      len_in   = len_ff;
      flags_in = flags_ff;
      hdr_in   = hdr_ff;
      pts_in   = pts_ff;
      dts_in   = dts_ff;
      if (q_pop) begin
         unique case (q_word.kind)
            K_ID: begin
               id_in   = q_word.data;
               skip_in = q_word.skipped;
            end
            K_LEN_HI:  len_in   = {q_word.data, len_ff[7:0]};
            K_LEN_LO:  len_in   = {len_ff[15:8], q_word.data};
            K_FLAGS:   flags_in = q_word.data[7:6];
            K_HDRLEN: begin
               hdr_in = q_word.data;
               pts_in = '0;
               dts_in = '0;
            end
            K_HDRDATA: begin
               if (q_word.ts_valid) begin
                  if (q_word.ts_index < TS_BYTES_PTS)
                     pts_in = ts_merge(pts_ff, q_word.ts_index[2:0], q_word.data);
                  else
                     dts_in = ts_merge(dts_ff, dts_k[2:0], q_word.data);
               end
            end
            default: id_in = id_ff;
         endcase
      end
   end

   assign sub  = {1'b0, hdr_in} + HDR_FIXED;
   assign diff = {1'b0, len_in} - {8'd0, sub};

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in              = 1'b1;
         out_in.stream_id          = id_in;
         out_in.packet_length      = len_in;
         out_in.pts_dts_flags      = flags_in;
         out_in.hdr_length         = hdr_in;
         out_in.pts                = q_word.status ? 33'd0 : pts_in;
         out_in.dts                = q_word.status ? 33'd0 : dts_in;
         out_in.payload_len        = diff[16] ? 16'd0 : diff[15:0];
         out_in.payload_unbounded  = diff[16];
         out_in.skipped_bytes      = skip_in;
         out_in.status             = q_word.status;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         id_ff        <= 8'd0;
         skip_ff      <= 16'd0;
         len_ff       <= 16'd0;
         flags_ff     <= 2'd0;
         hdr_ff       <= 8'd0;
         pts_ff       <= 33'd0;
         dts_ff       <= 33'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         id_ff        <= id_in;
         skip_ff      <= skip_in;
         len_ff       <= len_in;
         flags_ff     <= flags_in;
         hdr_ff       <= hdr_in;
         pts_ff       <= pts_in;
         dts_ff       <= dts_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

/* hdl/pes_header_parser_top.sv */
// Throughput: one stream byte per cycle; input stalls only when the word queue is full.
// Result path: the result word for a header is registered in the word queue and then in the
// output register, and can be held back in the queue while the result side stalls.
// Reset: synchronous, active high; parser hunts from an empty window, min stream id 188.
`timescale 1ns / 1ps

module pes_header_parser_top #(
   parameter int QUEUE_DEPTH = pesh_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // stream_id, packet_length, pts_dts_flags, hdr_length, pts, dts,
   // payload_len, payload_unbounded, skipped_bytes, zero pad
   output logic [135:0] rsp_tdata,
   output logic         rsp_tuser    // status
);
   import pesh_pkg::*;

   word_type   push_word, pop_word;
   logic       push, q_ready, q_valid, pop;
   result_type result;

   pesh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_byte     (req_tdata),
      .in_ready    (req_tready),
      .q_ready     (q_ready),
      .q_push      (push),
      .q_word      (push_word)
   );

   pesh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .ready     (q_ready),
      .pop       (pop),
      .pop_word  (pop_word),
      .valid     (q_valid)
   );

   pesh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_word     (pop_word),
      .q_pop      (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {3'd0,
                       result.skipped_bytes,
                       result.payload_unbounded,
                       result.payload_len,
                       result.dts,
                       result.pts,
                       result.hdr_length,
                       result.pts_dts_flags,
                       result.packet_length,
                       result.stream_id};
   assign rsp_tuser = result.status;

endmodule

/* sim/pes_header_parser_top_test.sv */
`timescale 1ns / 1ps

module pes_header_parser_top_test;
   import pesh_pkg::*;

   class pes_header_tracker;
      logic [7:0]  min_id;
      logic [23:0] window;
      logic [1:0]  fill;
      logic [15:0] skip;
      phase_type   ph;
      logic [7:0]  left;
      logic [3:0]  ts_idx;
      logic [7:0]  id;
      logic [15:0] len;
      logic [1:0]  flags;
      logic [7:0]  hlen;
      logic [32:0] pts_acc;
      logic [32:0] dts_acc;
      result_type  pending[$];
      int          errors;

      function new();
         min_id  = MIN_ID_RESET;
         left    = '0;
         ts_idx  = '0;
         id      = '0;
         len     = '0;
         flags   = '0;
         hlen    = '0;
         pts_acc = '0;
         dts_acc = '0;
         errors  = 0;
         restart();
      endfunction

      function void restart();
         window = WINDOW_EMPTY;
         ph     = PH_HUNT;
         fill   = '0;
         skip   = '0;
      endfunction

      function int waiting();
         return pending.size();
      endfunction

      // marker and prefix bits dropped: 3 + 15 + 15 bit groups
      function logic [32:0] ts_fold(logic [32:0] acc, logic [3:0] k, logic [7:0] b);
         case (k)
            4'd0: acc = {b[3:1], 30'd0};
            4'd1: acc = acc | {3'd0, b, 22'd0};
            4'd2: acc = acc | {11'd0, b[7:1], 15'd0};
            4'd3: acc = acc | {18'd0, b, 7'd0};
            default: acc = acc | {26'd0, b[7:1]};
         endcase
         return acc;
      endfunction

      function void close_header(logic status);
         result_type r;
         logic [15:0] sub;
         sub = {7'd0, HDR_FIXED + {1'b0, hlen}};
         r.stream_id       = id;
         r.packet_length   = len;
         r.pts_dts_flags   = flags;
         r.hdr_length      = hlen;
         r.pts             = (status == STATUS_FORMAT) ? 33'd0 : pts_acc;
         r.dts             = (status == STATUS_FORMAT) ? 33'd0 : dts_acc;
         if (len >= sub) begin
            r.payload_len       = len - sub;
            r.payload_unbounded = 1'b0;
         end else begin
            r.payload_len       = '0;
            r.payload_unbounded = 1'b1;
         end
         r.skipped_bytes = skip;
         r.status        = status;
         pending.push_back(r);
         restart();
      endfunction

      function void take_byte(logic [7:0] b);
         logic [3:0] need;
         case (ph)
            PH_LEN_HI: begin
               len = {b, 8'h00};
               ph  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len[7:0] = b;
               ph       = PH_FLAGS1;
            end
            PH_FLAGS1: ph = PH_FLAGS2;
            PH_FLAGS2: begin
               flags = b[7:6];
               ph    = PH_HDRLEN;
            end
            PH_HDRLEN: begin
               hlen    = b;
               left    = b;
               ts_idx  = '0;
               pts_acc = '0;
               dts_acc = '0;
               if (flags == FLAGS_INVALID) close_header(STATUS_FORMAT);
               else if (b == 8'd0) close_header(STATUS_OK);
               else ph = PH_HDRDATA;
            end
            PH_HDRDATA: begin
               need = (flags == FLAGS_PTS_DTS) ? TS_BYTES_BOTH :
                      (flags == FLAGS_PTS) ? TS_BYTES_PTS : TS_BYTES_NONE;
               if (ts_idx < need) begin
                  if (ts_idx < TS_BYTES_PTS) pts_acc = ts_fold(pts_acc, ts_idx, b);
                  else dts_acc = ts_fold(dts_acc, ts_idx - TS_BYTES_PTS, b);
                  ts_idx++;
               end
               left--;
               if (left == 8'd0) close_header(STATUS_OK);
            end
            default: begin
               if (window == PREFIX_CODE && b >= min_id) begin
                  id = b;
                  ph = PH_LEN_HI;
               end else begin
                  if (fill >= FILL_FULL) begin
                     if (skip != SKIP_MAX) skip++;
                  end else begin
                     fill++;
                  end
                  window = {window[15:0], b};
               end
            end
         endcase
      endfunction

      function void cmp(string name, logic [32:0] exp_v, logic [32:0] got_v);
         if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            errors++;
         end
      endfunction

      function void check_header(logic [135:0] d, logic st);
         result_type e;
         if (pending.size() == 0) begin
            $error("result word with no header pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         cmp("stream_id", 33'(e.stream_id), 33'(d[7:0]));
         cmp("packet_length", 33'(e.packet_length), 33'(d[23:8]));
         cmp("pts_dts_flags", 33'(e.pts_dts_flags), 33'(d[25:24]));
         cmp("hdr_length", 33'(e.hdr_length), 33'(d[33:26]));
         cmp("pts", e.pts, d[66:34]);
         cmp("dts", e.dts, d[99:67]);
         cmp("payload_len", 33'(e.payload_len), 33'(d[115:100]));
         cmp("payload_unbounded", 33'(e.payload_unbounded), 33'(d[116]));
         cmp("skipped_bytes", 33'(e.skipped_bytes), 33'(d[132:117]));
         cmp("status", 33'(e.status), 33'(st));
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [7:0]   csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;
   logic         rsp_tuser;

   pes_header_tracker tracker;
   bit tx_idle;
   bit rx_idle;
   bit hold_rsp;
   int bytes_sent;

   pes_header_parser_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_header(rsp_tdata, rsp_tuser);
   end

   // result side: per-word stall, plus one long hold-off on request
   initial begin
      int stall;
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         stall = rx_idle ? $urandom_range(0, 12) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready) && !(hold_rsp && !hold_done)) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_idle ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_header(input logic [7:0] id, input logic [15:0] len,
                              input logic [1:0] fl, input logic [7:0] hl);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(id);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      send_byte(8'($urandom_range(0, 255)));
      send_byte({fl, 6'($urandom_range(0, 63))});
      send_byte(hl);
      if (fl != FLAGS_INVALID) begin
         for (int i = 0; i < hl; i++) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic random_unit();
      int r;
      logic [7:0]  id;
      logic [7:0]  hl;
      logic [15:0] len;
      logic [1:0]  fl;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
         id = 8'($urandom_range(tracker.min_id, 255));
         case ($urandom_range(0, 4))
            0: len = 16'd0;
            1: len = 16'hFFFF;
            2: len = 16'($urandom_range(0, 20));
            default: len = 16'($urandom_range(0, 65535));
         endcase
         fl = 2'($urandom_range(0, 3));
         hl = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 255)) :
                                             8'($urandom_range(0, 14));
         send_header(id, len, fl, hl);
      end else if (r < 80) begin
         // prefix with an id below the threshold
         if (tracker.min_id != 8'd0) begin
            send_byte(8'h00);
            send_byte(8'h00);
            send_byte(8'h01);
            send_byte(8'($urandom_range(0, tracker.min_id - 1)));
         end
      end else if (r < 90) begin
         send_byte(8'h00);
         send_byte(8'h00);
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_idle();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (tracker.waiting() != 0 && n < 5000) begin
         @(negedge clock);
         n++;
      end
      if (tracker.waiting() != 0) begin
         $error("%0d header results never arrived", tracker.waiting());
         tracker.errors++;
         tracker.pending.delete();
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_min_id(input logic [7:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.min_id = v;
   endtask

   initial begin
      logic [7:0] opening[$];
      logic [7:0] min_ids[6];
      int phase_end;
      tracker = new();
      opening = '{8'h00, 8'h00, 8'h01, 8'hBB,
                  8'h00, 8'h00, 8'h01, 8'hBC, 8'h00, 8'h05, 8'h80, 8'h40, 8'h05,
                  8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h3F, 8'h00,
                  8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h00, 8'h80, 8'hC0, 8'h03,
                  8'hFF, 8'hFF, 8'hFF};
      min_ids = '{8'd0, 8'd255, 8'd0, 8'd188, 8'd0, 8'd1};
      min_ids[2] = 8'($urandom_range(1, 254));
      min_ids[4] = 8'($urandom_range(1, 254));
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      tx_idle     = 1'b0;
      rx_idle     = 1'b0;
      hold_rsp    = 1'b0;
      bytes_sent  = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ignored id, flags 01, empty header data, short header data
      foreach (opening[i]) send_byte(opening[i]);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         write_min_id(min_ids[p]);
         tx_idle = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
         rx_idle = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
         if (p == 3) begin
            // back-pressure: result side held while headers keep coming
            tx_idle  = 1'b0;
            hold_rsp = 1'b1;
            repeat (60) send_header(8'($urandom_range(tracker.min_id, 255)),
                                    16'($urandom_range(0, 65535)), FLAGS_PTS, 8'd0);
            rx_idle = 1'b1;
            tx_idle = 1'b1;
         end
         phase_end = bytes_sent + 200;
         while (bytes_sent < phase_end) random_unit();
         wait_idle();
      end

      // run of non-zero bytes ahead of a full PTS and DTS header
      write_min_id(MIN_ID_RESET);
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      repeat (40) send_byte(8'($urandom_range(1, 255)));
      send_header(8'hE0, 16'd40, FLAGS_PTS_DTS, 8'd10);
      wait_idle();

      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
